[hdl/bba_pkg.sv]
// shared constants, types and helper functions of the buddy block allocator
package bba_pkg;

    localparam int unsigned POOL_BYTES      = 1048576;
    localparam int unsigned MIN_BLOCK_BYTES = 256;
    localparam int unsigned TOP_ORDER       = 12;
    localparam int unsigned QUEUE_DEPTH     = 64;

    // item field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned REQ_W    = 21;
    localparam int unsigned ALIGN_W  = 17;
    localparam int unsigned UOFF_W   = 12;
    localparam int unsigned RORD_W   = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ABO_W    = 21;
    localparam int unsigned BORD_W   = 4;
    localparam int unsigned BYTES_W  = 21;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_APPLY   = 2'd2;

    localparam logic [STATUS_W-1:0] RES_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] RES_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_QUEUE_FULL = 2'd2;

    localparam int unsigned MIN_SHIFT   = $clog2(MIN_BLOCK_BYTES);
    localparam int unsigned UNIT_W      = TOP_ORDER;
    localparam int unsigned ORD_W       = $clog2(TOP_ORDER + 2);
    localparam int unsigned SZ_W        = REQ_W + 1;
    localparam int unsigned UNITS_W     = SZ_W + 1 - MIN_SHIFT;
    localparam int unsigned ORDC_W      = $clog2(UNITS_W + 1);
    localparam int unsigned POOL_MASKED = POOL_BYTES % (1 << BYTES_W);

    // free map is kept in words, each order starting on a word of its own
    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned WBIT_W    = $clog2(WORD_BITS);

    function automatic int unsigned order_words(input int unsigned j);
        int unsigned blocks;
        blocks = 1 << (TOP_ORDER - j);
        return (blocks > WORD_BITS) ? (blocks >> WBIT_W) : 1;
    endfunction

    function automatic int unsigned order_base(input int unsigned j);
        int unsigned s;
        s = 0;
        for (int unsigned i = 0; i <= TOP_ORDER; i++)
        begin
            if (i < j)
                s += order_words(i);
        end
        return s;
    endfunction

    localparam int unsigned MAP_DEPTH = order_base(TOP_ORDER + 1);
    localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
    localparam int unsigned WIDX_W    = (order_words(0) > 1) ? $clog2(order_words(0)) : 1;

    localparam int unsigned QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned QE_W   = UOFF_W + RORD_W;
    localparam int unsigned MCNT_W = $clog2(ABO_W + 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_QUEUE, S_SIZE, S_ORDER, S_SRCH_RD, S_SRCH_CHK,
        S_SPLIT_RD, S_SPLIT_WR, S_ACCT, S_MOD_WAIT, S_APPLY_RD, S_APPLY_CHK,
        S_MERGE_RD, S_MERGE_CHK, S_SET_RD, S_SET_WR, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_QUEUE, OP_SIZE, OP_ORDER, OP_SRCH_RD,
        OP_SRCH_CHK, OP_SPLIT_RD, OP_SPLIT_WR, OP_ACCT, OP_MOD_WAIT, OP_APPLY_RD,
        OP_APPLY_CHK, OP_MERGE_RD, OP_MERGE_CHK, OP_SET_RD, OP_SET_WR, OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic clear_done;
        logic size_fail;
        logic word_hit;
        logic search_end;
        logic split_done;
        logic need_align;
        logic mod_done;
        logic apply_done;
        logic entry_bad;
        logic at_top;
        logic buddy_free;
    } dp_status_t;

endpackage

[hdl/bba_if.sv]
// request and response channels of the allocator
interface bba_req_if import bba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [REQ_W-1:0]    req_bytes;
    logic [ALIGN_W-1:0]  align_bytes;
    logic [UOFF_W-1:0]   rel_unit_offset;
    logic [RORD_W-1:0]   rel_order;

    modport source (output valid, cmd, req_bytes, align_bytes, rel_unit_offset, rel_order,
                    input ready);
    modport sink (input valid, cmd, req_bytes, align_bytes, rel_unit_offset, rel_order,
                  output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ABO_W-1:0]    aligned_byte_offset;
    logic [UOFF_W-1:0]   unit_offset;
    logic [BORD_W-1:0]   block_order;

    modport source (output valid, status, aligned_byte_offset, unit_offset, block_order,
                    input ready);
    modport sink (input valid, status, aligned_byte_offset, unit_offset, block_order,
                  output ready);
endinterface

[hdl/bba_mod.sv]
// bit-serial remainder unit, one dividend bit per cycle
module bba_mod import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ABO_W-1:0]   dividend,
    input  logic [ALIGN_W-1:0] divisor,
    output logic               done,
    output logic [ALIGN_W-1:0] rem
);

    logic [ABO_W-1:0]   dvd_reg, dvd_next;
    logic [ALIGN_W-1:0] dvs_reg, dvs_next;
    logic [ALIGN_W-1:0] rem_reg, rem_next;
    logic [MCNT_W-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [ALIGN_W:0]   trial;
    logic [ALIGN_W-1:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[ABO_W-1]};
        rem_step = (trial >= {1'b0, dvs_reg}) ? ALIGN_W'(trial - {1'b0, dvs_reg})
                                              : ALIGN_W'(trial);
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = MCNT_W'(ABO_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MCNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

endmodule

[hdl/bba_datapath.sv]
// free map, release queue, size and alignment arithmetic of the allocator
module bba_datapath import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_op_t              op,
    input  logic [REQ_W-1:0]    req_bytes,
    input  logic [ALIGN_W-1:0]  align_bytes,
    input  logic [UOFF_W-1:0]   rel_unit_offset,
    input  logic [RORD_W-1:0]   rel_order,
    output dp_status_t          st,
    output logic [STATUS_W-1:0] status,
    output logic [ABO_W-1:0]    aligned_byte_offset,
    output logic [UOFF_W-1:0]   unit_offset,
    output logic [BORD_W-1:0]   block_order
);

    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ALIGN_W-1:0]  al_reg, al_next;
    logic [UOFF_W-1:0]   roff_reg, roff_next;
    logic [RORD_W-1:0]   rord_reg, rord_next;
    logic [SZ_W-1:0]     sz_reg, sz_next;
    logic [ORD_W-1:0]    ord_reg, ord_next;
    logic [ORD_W-1:0]    j_reg, j_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W-1:0]    mord_reg, mord_next;
    logic [RORD_W-1:0]   eord_reg, eord_next;
    logic [WIDX_W-1:0]   w_reg, w_next;
    logic [UNIT_W-1:0]   off_reg, off_next;
    logic [UNIT_W-1:0]   mblk_reg, mblk_next;
    logic [ABO_W-1:0]    boff_reg, boff_next;
    logic [STATUS_W-1:0] res_reg, res_next;
    logic                alloc_reg, alloc_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QCNT_W-1:0]   idx_reg, idx_next;
    logic [MAP_AW-1:0]   clr_reg, clr_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [ABO_W-1:0]    out_abo_reg;
    logic [UOFF_W-1:0]   out_uoff_reg;
    logic [BORD_W-1:0]   out_bord_reg;

    logic [WORD_BITS-1:0] map_mem [MAP_DEPTH];
    logic [WORD_BITS-1:0] map_q;
    logic [QE_W-1:0]      q_mem [QUEUE_DEPTH];
    logic [QE_W-1:0]      q_q;

    logic                 map_we, map_re, q_we, q_re;
    logic [MAP_AW-1:0]    map_wa, map_ra;
    logic [WORD_BITS-1:0] map_wd;

    logic                 pad;
    logic [SZ_W:0]        sz_round;
    logic [UNITS_W-1:0]   units, um1;
    logic [ORDC_W-1:0]    ord_calc;
    logic                 size_fail;
    logic                 word_nz, last_word, search_end;
    logic [WBIT_W-1:0]    pos;
    logic [UNIT_W-1:0]    found_blk, sblk, bud_blk;
    logic [ORD_W-1:0]     ksub;
    logic [MAP_AW-1:0]    srch_addr, split_addr, bud_addr, set_addr;
    logic [UOFF_W-1:0]    e_off;
    logic [RORD_W-1:0]    e_ord;
    logic                 entry_bad, buddy_free;
    logic                 mod_start, mod_done;
    logic [ALIGN_W-1:0]   mod_rem;

    function automatic logic [MAP_AW-1:0] map_addr(input logic [ORD_W-1:0] o,
                                                   input logic [UNIT_W-1:0] b);
        return MAP_AW'(order_base(int'(o)) + int'(b >> WBIT_W));
    endfunction

    function automatic logic [WORD_BITS-1:0] bit_of(input logic [UNIT_W-1:0] b);
        return WORD_BITS'(1) << WBIT_W'(b);
    endfunction

    always_comb
    begin
        // padding unless the alignment is zero or a power of two that divides the minimum block
        pad = (al_reg != '0) &&
              !(((al_reg & (al_reg - 1'b1)) == '0) && (al_reg <= MIN_BLOCK_BYTES));
        sz_round = {1'b0, sz_reg} + (SZ_W + 1)'(MIN_BLOCK_BYTES - 1);
        units    = sz_round[SZ_W:MIN_SHIFT];
        um1      = (units == '0) ? '0 : units - 1'b1;
        ord_calc = '0;
        for (int i = 0; i < UNITS_W; i++)
        begin
            if (um1[i])
                ord_calc = ORDC_W'(i + 1);
        end
        size_fail = (ord_calc > TOP_ORDER) || (bytes_reg == BYTES_W'(POOL_MASKED));

        word_nz = (map_q != '0);
        pos     = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (map_q[i])
                pos = WBIT_W'(i);
        end
        last_word  = (w_reg == WIDX_W'(order_words(int'(j_reg)) - 1));
        search_end = !word_nz && last_word && (j_reg == TOP_ORDER);
        found_blk  = UNIT_W'({w_reg, pos});

        ksub       = k_reg - 1'b1;
        sblk       = (off_reg >> ksub) + 1'b1;
        bud_blk    = mblk_reg ^ UNIT_W'(1);
        srch_addr  = MAP_AW'(order_base(int'(j_reg)) + int'(w_reg));
        split_addr = map_addr(ksub, sblk);
        bud_addr   = map_addr(mord_reg, bud_blk);
        set_addr   = map_addr(mord_reg, mblk_reg);
        buddy_free = map_q[WBIT_W'(bud_blk)];

        e_off     = q_q[QE_W-1:RORD_W];
        e_ord     = q_q[RORD_W-1:0];
        entry_bad = (e_ord > TOP_ORDER) ||
                    (((e_off >> e_ord) >> (TOP_ORDER - e_ord)) != '0);
    end

    always_comb
    begin
        st.clear_done = (clr_reg == MAP_AW'(MAP_DEPTH - 1));
        st.size_fail  = size_fail;
        st.word_hit   = word_nz;
        st.search_end = search_end;
        st.split_done = (k_reg == ord_reg);
        st.need_align = (al_reg != '0);
        st.mod_done   = mod_done;
        st.apply_done = (idx_reg == cnt_reg);
        st.entry_bad  = entry_bad;
        st.at_top     = (mord_reg == TOP_ORDER);
        st.buddy_free = buddy_free;
    end

    always_comb
    begin
        req_next   = req_reg;
        al_next    = al_reg;
        roff_next  = roff_reg;
        rord_next  = rord_reg;
        sz_next    = sz_reg;
        ord_next   = ord_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mord_next  = mord_reg;
        eord_next  = eord_reg;
        w_next     = w_reg;
        off_next   = off_reg;
        mblk_next  = mblk_reg;
        boff_next  = boff_reg;
        res_next   = res_reg;
        alloc_next = alloc_reg;
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        map_we     = 1'b0;
        map_wa     = srch_addr;
        map_wd     = map_q;
        map_re     = 1'b0;
        map_ra     = srch_addr;
        q_we       = 1'b0;
        q_re       = 1'b0;
        mod_start  = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                map_we   = 1'b1;
                map_wa   = clr_reg;
                map_wd   = (clr_reg == MAP_AW'(order_base(TOP_ORDER))) ? WORD_BITS'(1) : '0;
                clr_next = clr_reg + 1'b1;
            end
            OP_LOAD:
            begin
                req_next   = req_bytes;
                al_next    = align_bytes;
                roff_next  = rel_unit_offset;
                rord_next  = rel_order;
                res_next   = RES_OK;
                alloc_next = 1'b0;
                idx_next   = '0;
            end
            OP_QUEUE:
            begin
                if (cnt_reg == QCNT_W'(QUEUE_DEPTH))
                    res_next = RES_QUEUE_FULL;
                else
                begin
                    q_we     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_SIZE:
            begin
                sz_next = SZ_W'(req_reg) + (pad ? SZ_W'(al_reg) : '0);
            end
            OP_ORDER:
            begin
                if (size_fail)
                    res_next = RES_NO_SPACE;
                else
                begin
                    ord_next = ORD_W'(ord_calc);
                    j_next   = ORD_W'(ord_calc);
                    w_next   = '0;
                end
            end
            OP_SRCH_RD:
            begin
                map_re = 1'b1;
            end
            OP_SRCH_CHK:
            begin
                if (word_nz)
                begin
                    map_we   = 1'b1;
                    map_wd   = map_q & ~(WORD_BITS'(1) << pos);
                    off_next = found_blk << j_reg;
                    k_next   = j_reg;
                end
                else if (search_end)
                    res_next = RES_NO_SPACE;
                else if (last_word)
                begin
                    j_next = j_reg + 1'b1;
                    w_next = '0;
                end
                else
                    w_next = w_reg + 1'b1;
            end
            OP_SPLIT_RD:
            begin
                map_re = (k_reg != ord_reg);
                map_ra = split_addr;
            end
            OP_SPLIT_WR:
            begin
                // right half of the split block becomes free
                map_we = 1'b1;
                map_wa = split_addr;
                map_wd = map_q | bit_of(sblk);
                k_next = ksub;
            end
            OP_ACCT:
            begin
                bytes_next = bytes_reg + (BYTES_W'(MIN_BLOCK_BYTES) << ord_reg);
                boff_next  = ABO_W'(off_reg) << MIN_SHIFT;
                alloc_next = 1'b1;
                mod_start  = (al_reg != '0);
            end
            OP_MOD_WAIT:
            begin
                if (mod_done && (mod_rem != '0))
                    boff_next = boff_reg + ABO_W'(al_reg) - ABO_W'(mod_rem);
            end
            OP_APPLY_RD:
            begin
                if (idx_reg == cnt_reg)
                    cnt_next = '0;
                else
                    q_re = 1'b1;
            end
            OP_APPLY_CHK:
            begin
                if (entry_bad)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    eord_next = e_ord;
                    mord_next = ORD_W'(e_ord);
                    mblk_next = UNIT_W'(e_off >> e_ord);
                end
            end
            OP_MERGE_RD:
            begin
                map_re = (mord_reg != TOP_ORDER);
                map_ra = bud_addr;
            end
            OP_MERGE_CHK:
            begin
                if (buddy_free)
                begin
                    map_we    = 1'b1;
                    map_wa    = bud_addr;
                    map_wd    = map_q & ~bit_of(bud_blk);
                    mblk_next = mblk_reg >> 1;
                    mord_next = mord_reg + 1'b1;
                end
            end
            OP_SET_RD:
            begin
                map_re = 1'b1;
                map_ra = set_addr;
            end
            OP_SET_WR:
            begin
                map_we     = 1'b1;
                map_wa     = set_addr;
                map_wd     = map_q | bit_of(mblk_reg);
                bytes_next = bytes_reg - (BYTES_W'(MIN_BLOCK_BYTES) << eord_reg);
                idx_next   = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        al_reg    <= al_next;
        roff_reg  <= roff_next;
        rord_reg  <= rord_next;
        sz_reg    <= sz_next;
        ord_reg   <= ord_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        mord_reg  <= mord_next;
        eord_reg  <= eord_next;
        w_reg     <= w_next;
        off_reg   <= off_next;
        mblk_reg  <= mblk_next;
        boff_reg  <= boff_next;
        res_reg   <= res_next;
        alloc_reg <= alloc_next;
        idx_reg   <= idx_next;
        if (op == OP_DONE)
        begin
            out_status_reg <= res_reg;
            out_abo_reg    <= alloc_reg ? boff_reg : '0;
            out_uoff_reg   <= alloc_reg ? UOFF_W'(off_reg) : '0;
            out_bord_reg   <= alloc_reg ? BORD_W'(ord_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (map_re)
            map_q <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[cnt_reg[QA_W-1:0]] <= {roff_reg, rord_reg};
        if (q_re)
            q_q <= q_mem[idx_reg[QA_W-1:0]];
    end

    bba_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (ABO_W'(off_reg) << MIN_SHIFT),
        .divisor  (al_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign status              = out_status_reg;
    assign aligned_byte_offset = out_abo_reg;
    assign unit_offset         = out_uoff_reg;
    assign block_order         = out_bord_reg;

    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_QUEUE && cnt_reg != QCNT_W'(QUEUE_DEPTH)) |=>
            (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("release not counted");

    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_SET_WR) |-> (mord_reg <= TOP_ORDER))
        else $error("merge walked past the top order");

endmodule

[hdl/bba_ctrl.sv]
// sequencer of the allocator: clearing pass, allocate, queue and apply flows
module bba_ctrl import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  dp_status_t       st,
    output dp_op_t           op
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_out;

    assign can_out = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     if (st.clear_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_ALLOC:   state_next = S_SIZE;
                        CMD_RELEASE: state_next = S_QUEUE;
                        CMD_APPLY:   state_next = S_APPLY_RD;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_QUEUE:     state_next = S_DONE;
            S_SIZE:      state_next = S_ORDER;
            S_ORDER:     state_next = st.size_fail ? S_DONE : S_SRCH_RD;
            S_SRCH_RD:   state_next = S_SRCH_CHK;
            S_SRCH_CHK:
            begin
                if (st.word_hit)
                    state_next = S_SPLIT_RD;
                else if (st.search_end)
                    state_next = S_DONE;
                else
                    state_next = S_SRCH_RD;
            end
            S_SPLIT_RD:  state_next = st.split_done ? S_ACCT : S_SPLIT_WR;
            S_SPLIT_WR:  state_next = S_SPLIT_RD;
            S_ACCT:      state_next = st.need_align ? S_MOD_WAIT : S_DONE;
            S_MOD_WAIT:  if (st.mod_done) state_next = S_DONE;
            S_APPLY_RD:  state_next = st.apply_done ? S_DONE : S_APPLY_CHK;
            S_APPLY_CHK: state_next = st.entry_bad ? S_APPLY_RD : S_MERGE_RD;
            S_MERGE_RD:  state_next = st.at_top ? S_SET_RD : S_MERGE_CHK;
            S_MERGE_CHK: state_next = st.buddy_free ? S_MERGE_RD : S_SET_RD;
            S_SET_RD:    state_next = S_SET_WR;
            S_SET_WR:    state_next = S_APPLY_RD;
            S_DONE:      if (can_out) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op             = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:     op = OP_CLEAR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    op = OP_LOAD;
            end
            S_QUEUE:     op = OP_QUEUE;
            S_SIZE:      op = OP_SIZE;
            S_ORDER:     op = OP_ORDER;
            S_SRCH_RD:   op = OP_SRCH_RD;
            S_SRCH_CHK:  op = OP_SRCH_CHK;
            S_SPLIT_RD:  op = OP_SPLIT_RD;
            S_SPLIT_WR:  op = OP_SPLIT_WR;
            S_ACCT:      op = OP_ACCT;
            S_MOD_WAIT:  op = OP_MOD_WAIT;
            S_APPLY_RD:  op = OP_APPLY_RD;
            S_APPLY_CHK: op = OP_APPLY_CHK;
            S_MERGE_RD:  op = OP_MERGE_RD;
            S_MERGE_CHK: op = OP_MERGE_CHK;
            S_SET_RD:    op = OP_SET_RD;
            S_SET_WR:    op = OP_SET_WR;
            S_DONE:
            begin
                if (can_out)
                begin
                    op             = OP_DONE;
                    out_valid_next = 1'b1;
                end
            end
            default:     op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

endmodule

[hdl/buddy_block_allocator.sv]
// buddy block allocator: free map per order, release queue, merge on apply
// after reset a clearing pass sets up the free map; no item is taken until then
// allocate: a scan of the free map word by word, one split per level down to the order,
//   then the bit-serial alignment remainder when an alignment is given
// release: a push onto the queue; apply: each queued item in turn, skipped if bad, merged level by level
// one item at a time; the next item is taken while the previous result waits in its register
module buddy_block_allocator import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);

    dp_op_t     op;
    dp_status_t st;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_cmd    (req.cmd),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .st        (st),
        .op        (op)
    );

    bba_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .req_bytes           (req.req_bytes),
        .align_bytes         (req.align_bytes),
        .rel_unit_offset     (req.rel_unit_offset),
        .rel_order           (req.rel_order),
        .st                  (st),
        .status              (rsp.status),
        .aligned_byte_offset (rsp.aligned_byte_offset),
        .unit_offset         (rsp.unit_offset),
        .block_order         (rsp.block_order)
    );

endmodule

[tb/sv/tb_buddy_block_allocator.sv]
// self-checking testbench of the buddy block allocator with its own allocator model
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int unsigned NUM_RANDOM = 1625;
    localparam int unsigned UNITS = 1 << TOP_ORDER;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [REQ_W-1:0]   req_bytes;
        logic [ALIGN_W-1:0] align_bytes;
        logic [UOFF_W-1:0]  rel_unit_offset;
        logic [RORD_W-1:0]  rel_order;
    } alloc_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ABO_W-1:0]    aligned_byte_offset;
        logic [UOFF_W-1:0]   unit_offset;
        logic [BORD_W-1:0]   block_order;
    } alloc_rsp_t;

    typedef struct packed {
        alloc_cmd_t item;
        logic       typed;
        alloc_rsp_t answer;
    } table_row_t;

    typedef struct packed {
        logic [UOFF_W-1:0] offset;
        logic [RORD_W-1:0] order;
    } block_t;

    logic clk;
    logic rst_n;
    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // model state
    bit                 free_bits [0:TOP_ORDER][0:UNITS-1];
    logic [BYTES_W-1:0] bytes_used;
    block_t             pending_rel [0:QUEUE_DEPTH-1];
    int unsigned        pending_cnt;

    alloc_rsp_t  awaited_rsp [$];
    block_t      live_blocks [$];
    bit          failed;
    int unsigned rsp_cycle;

    table_row_t directed_tab [0:18] = '{
        '{'{CMD_ALLOC, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b1, '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_ALLOC, 21'd1048576, 17'd0, 12'd0, 4'd0}, 1'b1,
          '{RES_NO_SPACE, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_ALLOC, 21'h1FFFFF, 17'h1FFFF, 12'd0, 4'd0}, 1'b1,
          '{RES_NO_SPACE, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_RELEASE, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b1, '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_APPLY, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b1, '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_ALLOC, 21'd1048576, 17'd0, 12'd0, 4'd0}, 1'b1,
          '{RES_OK, 21'd0, 12'd0, 4'd12}},
        '{'{CMD_ALLOC, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b1,
          '{RES_NO_SPACE, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_NONE, 21'h1FFFFF, 17'h1FFFF, 12'hFFF, 4'hF}, 1'b1,
          '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_RELEASE, 21'd0, 17'd0, 12'hFFF, 4'd12}, 1'b1, '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_APPLY, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b1, '{RES_OK, 21'd0, 12'd0, 4'd0}},
        '{'{CMD_ALLOC, 21'd100, 17'd3, 12'd0, 4'd0}, 1'b0, '0},
        '{'{CMD_ALLOC, 21'd300, 17'd65536, 12'd0, 4'd0}, 1'b0, '0},
        '{'{CMD_ALLOC, 21'd5000, 17'd128, 12'd0, 4'd0}, 1'b0, '0},
        '{'{CMD_ALLOC, 21'd256, 17'd1, 12'd0, 4'd0}, 1'b0, '0},
        '{'{CMD_RELEASE, 21'd0, 17'd0, 12'hFFF, 4'hF}, 1'b0, '0},
        '{'{CMD_RELEASE, 21'd0, 17'd0, 12'd0, 4'd13}, 1'b0, '0},
        '{'{CMD_RELEASE, 21'd0, 17'd0, 12'd7, 4'd0}, 1'b0, '0},
        '{'{CMD_APPLY, 21'd0, 17'd0, 12'd0, 4'd0}, 1'b0, '0},
        '{'{CMD_ALLOC, 21'd1, 17'd131071, 12'd0, 4'd0}, 1'b0, '0}
    };

    function automatic void reset_model();
        foreach (free_bits[o, b])
            free_bits[o][b] = 1'b0;
        free_bits[TOP_ORDER][0] = 1'b1;
        bytes_used  = '0;
        pending_cnt = 0;
    endfunction

    function automatic alloc_rsp_t model_alloc(logic [REQ_W-1:0] bytes,
                                               logic [ALIGN_W-1:0] align);
        alloc_rsp_t        r;
        longint unsigned   sz;
        longint unsigned   units;
        longint unsigned   al;
        longint unsigned   boff;
        longint unsigned   off;
        int unsigned       o;
        int unsigned       j;
        int unsigned       k;
        int unsigned       blk;
        bit                found;
        r = '0;
        sz = bytes;
        al = align;
        found = 1'b0;
        blk = 0;
        if (al != 0 && (MIN_BLOCK_BYTES % al) != 0)
            sz += al;
        units = (sz + MIN_BLOCK_BYTES - 1) / MIN_BLOCK_BYTES;
        if (units == 0)
            units = 1;
        o = 0;
        while (o <= TOP_ORDER && (64'd1 << o) < units)
            o++;
        if (o > TOP_ORDER || bytes_used == POOL_MASKED)
        begin
            r.status = RES_NO_SPACE;
            return r;
        end
        for (j = o; j <= TOP_ORDER; j++)
        begin
            for (int unsigned b = 0; b < (1 << (TOP_ORDER - j)); b++)
            begin
                if (free_bits[j][b])
                begin
                    blk = b;
                    found = 1'b1;
                    break;
                end
            end
            if (found)
                break;
        end
        if (!found)
        begin
            r.status = RES_NO_SPACE;
            return r;
        end
        free_bits[j][blk] = 1'b0;
        off = longint'(blk) << j;
        // split down, right halves become free
        for (k = j; k > o; k--)
            free_bits[k-1][(off >> (k-1)) + 1] = 1'b1;
        bytes_used = bytes_used + BYTES_W'(MIN_BLOCK_BYTES << o);
        boff = off * MIN_BLOCK_BYTES;
        if (al != 0 && (boff % al) != 0)
            boff = ((boff + al - 1) / al) * al;
        r.status = RES_OK;
        r.aligned_byte_offset = boff[ABO_W-1:0];
        r.unit_offset = off[UOFF_W-1:0];
        r.block_order = o[BORD_W-1:0];
        return r;
    endfunction

    function automatic void model_apply();
        int unsigned o;
        int unsigned blk;
        for (int unsigned i = 0; i < pending_cnt; i++)
        begin
            o = pending_rel[i].order;
            if (o > TOP_ORDER)
                continue;
            blk = pending_rel[i].offset >> o;
            if (blk >= (1 << (TOP_ORDER - o)))
                continue;
            bytes_used = bytes_used - BYTES_W'(MIN_BLOCK_BYTES << o);
            // merge upward while the buddy is free
            while (o < TOP_ORDER && free_bits[o][blk ^ 1])
            begin
                free_bits[o][blk ^ 1] = 1'b0;
                blk = blk >> 1;
                o++;
            end
            free_bits[o][blk] = 1'b1;
        end
        pending_cnt = 0;
    endfunction

    function automatic alloc_rsp_t predict_alloc_rsp(alloc_cmd_t it);
        alloc_rsp_t r;
        r = '0;
        case (it.cmd)
            CMD_ALLOC:
                r = model_alloc(it.req_bytes, it.align_bytes);
            CMD_RELEASE:
            begin
                if (pending_cnt >= QUEUE_DEPTH)
                    r.status = RES_QUEUE_FULL;
                else
                begin
                    pending_rel[pending_cnt] = '{it.rel_unit_offset, it.rel_order};
                    pending_cnt++;
                end
            end
            CMD_APPLY:
                model_apply();
            default: ;
        endcase
        return r;
    endfunction

    function automatic alloc_cmd_t random_cmd(int unsigned idx);
        alloc_cmd_t  it;
        int unsigned pick;
        int unsigned sel;
        it = '0;
        it.req_bytes = REQ_W'($urandom);
        it.align_bytes = ALIGN_W'($urandom);
        it.rel_unit_offset = UOFF_W'($urandom);
        it.rel_order = RORD_W'($urandom);
        pick = $urandom_range(0, 99);
        // a burst of releases to run the queue past full
        if (idx >= 800 && idx < 870)
            pick = 60;
        if (pick < 45)
        begin
            it.cmd = CMD_ALLOC;
            sel = $urandom_range(0, 99);
            if (sel < 80)
                it.req_bytes = REQ_W'($urandom_range(0, 4096));
            else if (sel < 96)
                it.req_bytes = REQ_W'($urandom_range(0, 65536));
            else if (sel < 98)
                it.req_bytes = REQ_W'($urandom_range(0, POOL_BYTES));
            sel = $urandom_range(0, 99);
            if (sel < 50)
                it.align_bytes = '0;
            else if (sel < 85)
                it.align_bytes = ALIGN_W'(1 << $urandom_range(0, 16));
            else if (sel < 95)
                it.align_bytes = ALIGN_W'($urandom_range(1, 1000));
        end
        else if (pick < 82)
        begin
            it.cmd = CMD_RELEASE;
            if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0)
            begin
                sel = $urandom_range(0, live_blocks.size() - 1);
                it.rel_unit_offset = live_blocks[sel].offset;
                it.rel_order = live_blocks[sel].order;
                live_blocks.delete(sel);
            end
        end
        else if (pick < 98)
            it.cmd = CMD_APPLY;
        else
            it.cmd = CMD_NONE;
        return it;
    endfunction

    task automatic send_cmd(alloc_cmd_t it, bit typed, alloc_rsp_t answer, bit gaps);
        alloc_rsp_t r;
        block_t     held;
        if (gaps && $urandom_range(0, 99) < 13)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.cmd             <= it.cmd;
        req.req_bytes       <= it.req_bytes;
        req.align_bytes     <= it.align_bytes;
        req.rel_unit_offset <= it.rel_unit_offset;
        req.rel_order       <= it.rel_order;
        do
            @(posedge clk);
        while (!req.ready);
        r = predict_alloc_rsp(it);
        if (it.cmd == CMD_ALLOC && r.status == RES_OK)
        begin
            held.offset = r.unit_offset;
            held.order  = r.block_order;
            live_blocks.insert(live_blocks.size(), held);
        end
        awaited_rsp.insert(awaited_rsp.size(), typed ? answer : r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("Some tests failed");
        $finish;
    end

    // response side: random stall, one long hold-off, one stretch always ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_cycle <= 0;
        end
        else
        begin
            rsp_cycle <= rsp_cycle + 1;
            if (rsp_cycle >= 3000 && rsp_cycle < 3600)
                rsp.ready <= 1'b0;
            else if (rsp_cycle >= 8000 && rsp_cycle < 20000)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 99) >= 13);
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected item %p", $realtime, rsp.status);
                    failed <= 1'b1;
                end
                else
                begin
                    if (rsp.status !== awaited_rsp[0].status
                        || rsp.aligned_byte_offset !== awaited_rsp[0].aligned_byte_offset
                        || rsp.unit_offset !== awaited_rsp[0].unit_offset
                        || rsp.block_order !== awaited_rsp[0].block_order)
                    begin
                        $display("%0t: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                                 $realtime, awaited_rsp[0].status,
                                 awaited_rsp[0].aligned_byte_offset,
                                 awaited_rsp[0].unit_offset, awaited_rsp[0].block_order,
                                 rsp.status, rsp.aligned_byte_offset, rsp.unit_offset,
                                 rsp.block_order);
                        failed <= 1'b1;
                    end
                    void'(awaited_rsp.pop_front());
                end
            end
        end
    end

    initial
    begin
        int unsigned wait_cnt;
        failed = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_ALLOC;
        req.req_bytes = '0;
        req.align_bytes = '0;
        req.rel_unit_offset = '0;
        req.rel_order = '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_tab[i])
            send_cmd(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].answer,
                     1'b1);
        for (int unsigned n = 0; n < NUM_RANDOM; n++)
            send_cmd(random_cmd(n), 1'b0, '0, !(n >= 300 && n < 600));
        req.valid <= 1'b0;
        wait_cnt = 0;
        while (awaited_rsp.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (400) @(posedge clk);
        if (failed || awaited_rsp.size() != 0)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
